// File: src/assert_macros.svh
// Assertion macros for the RTL files that carry checks.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is held.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be seen at a clock edge.
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// File: src/bdq_pkg.sv
// Shared types and constants of the bounded deque.
// No dependencies; imported by every bdq module but bdq_ram.
package bdq_pkg;

  localparam int unsigned DEPTH_DEFAULT = 16;
  localparam int unsigned VALUE_W       = 32;
  localparam int unsigned OCC_W         = 5;

  typedef enum logic [2:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_POP_BACK   = 3'd1,
    OP_PUSH_FRONT = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_DUMP       = 3'd4
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_RESP = 2'd1,
    S_DUMP = 2'd2
  } state_e;

  typedef struct packed {
    logic [2:0]                opcode;
    logic signed [VALUE_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic [1:0]                status;
    logic signed [VALUE_W-1:0] element;
    logic                      last;
    logic [OCC_W-1:0]          occupancy;
  } out_word_t;

  // controller to datapath
  typedef struct packed {
    logic exec;       // input word accepted this cycle
    logic dump_next;  // dump element taken, fetch the following one
    logic dump_mode;  // output shows the dump stream
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic dump_go;    // current input is a dump of a non-empty queue
    logic dump_last;  // dump element on show is the back one
  } stat_t;

endpackage

// File: src/bdq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module bdq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/bdq_ctrl.sv
// Handshake controller of the bounded deque.
// Depends on bdq_pkg (state, command and status types).
module bdq_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  bdq_pkg::stat_t stat_i,
  output bdq_pkg::cmd_t  cmd_o
);
  import bdq_pkg::*;

  state_e state_q, state_d;
  logic   accept;

  assign accept = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE, S_RESP: begin
        if (accept) begin
          state_d = stat_i.dump_go ? S_DUMP : S_RESP;
        end else if (state_q == S_RESP && out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      S_DUMP: begin
        if (out_ready_i && stat_i.dump_last) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o      = 1'b0;
    out_valid_o     = 1'b0;
    cmd_o.exec      = 1'b0;
    cmd_o.dump_next = 1'b0;
    cmd_o.dump_mode = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.exec = in_valid_i;
      end
      S_RESP: begin
        out_valid_o = 1'b1;
        in_ready_o  = out_ready_i;
        cmd_o.exec  = in_valid_i && out_ready_i;
      end
      S_DUMP: begin
        out_valid_o     = 1'b1;
        cmd_o.dump_mode = 1'b1;
        cmd_o.dump_next = out_ready_i && !stat_i.dump_last;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

// File: src/bdq_datapath.sv
// Datapath of the bounded deque: ring pointers, count, element store, result word.
// Depends on bdq_pkg and bdq_ram.
module bdq_datapath #(
  parameter int unsigned DEPTH = bdq_pkg::DEPTH_DEFAULT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bdq_pkg::in_word_t  in_data_i,
  input  bdq_pkg::cmd_t      cmd_i,
  output bdq_pkg::stat_t     stat_o,
  output bdq_pkg::out_word_t out_data_o
);
  import bdq_pkg::*;

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [IW-1:0]      front_q, front_d;
  logic [CW-1:0]      count_q, count_d;
  logic [IW-1:0]      k_q, k_d;
  logic [1:0]         status_q, status_d;
  logic               full, empty;
  logic               we, re;
  logic [IW-1:0]      waddr, raddr;
  logic [VALUE_W-1:0] rdata;
  logic [IW-1:0]      front_dec, front_inc;
  logic [CW+OCC_W-1:0] count_ext;

  // (base + off) mod DEPTH, both operands below DEPTH
  function automatic logic [IW-1:0] ring_pos(input logic [IW-1:0] base,
                                             input logic [IW-1:0] off);
    logic [IW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= (IW+1)'(DEPTH)) begin
      sum = sum - (IW+1)'(DEPTH);
    end
    return sum[IW-1:0];
  endfunction

  assign full      = (count_q == CW'(DEPTH));
  assign empty     = (count_q == '0);
  assign front_dec = (front_q == '0) ? IW'(DEPTH - 1) : front_q - IW'(1);
  assign front_inc = (front_q == IW'(DEPTH - 1)) ? '0 : front_q + IW'(1);

  assign stat_o.dump_go   = (in_data_i.opcode == OP_DUMP) && !empty;
  assign stat_o.dump_last = ((CW'(k_q) + CW'(1)) == count_q);

  always_comb begin
    front_d  = front_q;
    count_d  = count_q;
    k_d      = k_q;
    status_d = status_q;
    we       = 1'b0;
    waddr    = ring_pos(front_q, IW'(count_q));
    re       = 1'b0;
    raddr    = front_q;
    if (cmd_i.exec) begin
      status_d = ST_OK;
      case (in_data_i.opcode)
        OP_PUSH_BACK: begin
          if (full) begin
            status_d = ST_FULL;
          end else begin
            we      = 1'b1;
            count_d = count_q + CW'(1);
          end
        end
        OP_PUSH_FRONT: begin
          if (full) begin
            status_d = ST_FULL;
          end else begin
            we      = 1'b1;
            waddr   = front_dec;
            front_d = front_dec;
            count_d = count_q + CW'(1);
          end
        end
        OP_POP_BACK: begin
          if (empty) begin
            status_d = ST_EMPTY;
          end else begin
            count_d = count_q - CW'(1);
          end
        end
        OP_POP_FRONT: begin
          if (empty) begin
            status_d = ST_EMPTY;
          end else begin
            front_d = front_inc;
            count_d = count_q - CW'(1);
          end
        end
        OP_DUMP: begin
          if (empty) begin
            status_d = ST_EMPTY;
          end else begin
            re  = 1'b1;
            k_d = '0;
          end
        end
        default: status_d = ST_OK;
      endcase
    end else if (cmd_i.dump_next) begin
      re    = 1'b1;
      raddr = ring_pos(front_q, k_q + IW'(1));
      k_d   = k_q + IW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      count_q <= '0;
    end else begin
      front_q <= front_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q      <= k_d;
    status_q <= status_d;
  end

  bdq_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (in_data_i.value),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // occupancy is the count masked to the field width
  assign count_ext = {{OCC_W{1'b0}}, count_q};

  always_comb begin
    out_data_o.occupancy = count_ext[OCC_W-1:0];
    if (cmd_i.dump_mode) begin
      out_data_o.status  = ST_OK;
      out_data_o.element = rdata;
      out_data_o.last    = stat_o.dump_last;
    end else begin
      out_data_o.status  = status_q;
      out_data_o.element = '0;
      out_data_o.last    = 1'b1;
    end
  end

endmodule

// File: src/bounded_deque_top.sv
// Top level of the bounded deque: controller plus datapath.
// Depends on bdq_pkg, bdq_ctrl, bdq_datapath, bdq_ram and assert_macros.svh.

// Double-ended queue of signed 32-bit words held in a ring store of DEPTH
// entries. Opcodes: push back, pop back, push front, pop front,
// dump. Every opcode but a dump of a non-empty queue gives one result word
// with last set; status tells ok, empty (pop or dump with nothing stored) or
// full (push dropped). A dump gives one word per stored element, front to
// back, last set on the back one. Occupancy is the count after the
// operation, masked to 5 bits. Timing: a non-dump word is accepted, its
// result shows the next cycle, and the next input word is taken in the same
// cycle that result is taken, so with out_ready_i held high one word per
// cycle goes through. In a dump, the accept cycle issues the first store
// read, then one element per cycle goes out while out_ready_i is high, as
// the ring store has a registered read port. No input is taken during a
// dump. The store needs no clearing after reset.
module bounded_deque_top #(
  parameter int unsigned DEPTH = bdq_pkg::DEPTH_DEFAULT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  bdq_pkg::in_word_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output bdq_pkg::out_word_t out_data_o
);
  import bdq_pkg::*;

  `include "assert_macros.svh"

  cmd_t  cmd;   // sequencing commands into the datapath
  stat_t stat;  // decode and dump-progress flags back to the controller

  bdq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  bdq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_data_o (out_data_o)
  );

  // an accepted word always has a result on show the cycle after
  `ASSERT_CLK(a_exec_gives_result, cmd.exec |=> out_valid_o, "accepted word gave no result")
  // the dump stream holds the input side off
  `ASSERT_NEVER(a_no_accept_in_dump, cmd.dump_mode && in_ready_o, "input taken during dump")
  // an error status is a lone result word with no element
  `ASSERT_CLK(a_error_is_last,
    out_valid_o && out_data_o.status != ST_OK |-> out_data_o.last && out_data_o.element == '0,
    "error result not final or carries element")
  // fetching the next dump element keeps the dump stream going
  `ASSERT_CLK(a_dump_continues, cmd.dump_next |=> cmd.dump_mode, "dump stream cut short")

endmodule

// File: tb/tb_bounded_deque_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for bounded_deque_top: a directed table, then random opcode streams.
// Results are checked against a shadow deque kept here. Depends on bdq_pkg and the RTL.
module tb_bounded_deque_top;
  import bdq_pkg::*;

  localparam int unsigned DEPTH        = DEPTH_DEFAULT;
  localparam int unsigned RANDOM_ITEMS = 320;
  localparam int unsigned STALL_LIMIT  = 1000;  // cycles with no word moving
  localparam int unsigned DRAIN_CYCLES = 20;

  // opcodes outside the defined set; the block must answer ok and leave state alone
  localparam logic [2:0] OP_RSVD_LO  = 3'd5;
  localparam logic [2:0] OP_RSVD_MID = 3'd6;
  localparam logic [2:0] OP_RSVD_HI  = 3'd7;

  localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;

  typedef enum {LEAN_FILL, LEAN_DRAIN, LEAN_EVEN} lean_e;

  // one row of the directed table; lit_on marks a result typed in by hand
  typedef struct {
    logic [2:0]                opcode;
    logic signed [VALUE_W-1:0] value;
    int unsigned               reps;
    logic                      lit_on;
    out_word_t                 lit;
  } dir_row_t;

  typedef struct {
    logic      lit_on;
    out_word_t lit;
  } fixed_t;

  localparam int unsigned DIR_ROWS = 25;

  // front/back order, wrap of the ring, full and empty edges
  dir_row_t dir_tab [DIR_ROWS] = '{
    '{OP_POP_BACK,   '0,            1,  1'b1, '{ST_EMPTY, '0, 1'b1, 5'd0}},
    '{OP_POP_FRONT,  '0,            1,  1'b1, '{ST_EMPTY, '0, 1'b1, 5'd0}},
    '{OP_DUMP,       '0,            1,  1'b1, '{ST_EMPTY, '0, 1'b1, 5'd0}},
    '{OP_PUSH_BACK,  VAL_MAX,       1,  1'b1, '{ST_OK,    '0, 1'b1, 5'd1}},
    '{OP_PUSH_FRONT, VAL_MIN,       1,  1'b1, '{ST_OK,    '0, 1'b1, 5'd2}},
    '{OP_PUSH_BACK,  '0,            1,  1'b0, '0},
    '{OP_PUSH_FRONT, -32'sd1,       1,  1'b0, '0},
    '{OP_DUMP,       '0,            1,  1'b0, '0},
    '{OP_RSVD_LO,    -32'sd1,       1,  1'b1, '{ST_OK,    '0, 1'b1, 5'd4}},
    '{OP_RSVD_MID,   32'sh5555_5555, 1, 1'b1, '{ST_OK,    '0, 1'b1, 5'd4}},
    '{OP_RSVD_HI,    32'shAAAA_AAAA, 1, 1'b1, '{ST_OK,    '0, 1'b1, 5'd4}},
    '{OP_POP_BACK,   '0,            1,  1'b1, '{ST_OK,    '0, 1'b1, 5'd3}},
    '{OP_POP_FRONT,  '0,            1,  1'b1, '{ST_OK,    '0, 1'b1, 5'd2}},
    '{OP_DUMP,       '0,            1,  1'b0, '0},
    '{OP_PUSH_FRONT, 32'sh1000_0000, 7, 1'b0, '0},
    '{OP_PUSH_BACK,  32'sh2000_0000, 7, 1'b0, '0},
    '{OP_PUSH_BACK,  32'sd1,        1,  1'b1, '{ST_FULL,  '0, 1'b1, 5'd16}},
    '{OP_PUSH_FRONT, 32'sd2,        1,  1'b1, '{ST_FULL,  '0, 1'b1, 5'd16}},
    '{OP_DUMP,       '0,            1,  1'b0, '0},
    '{OP_POP_FRONT,  '0,            9,  1'b0, '0},
    '{OP_PUSH_BACK,  32'sh7FFF_FFF0, 5, 1'b0, '0},
    '{OP_DUMP,       '0,            1,  1'b0, '0},
    '{OP_POP_BACK,   '0,            12, 1'b0, '0},
    '{OP_POP_BACK,   '0,            1,  1'b1, '{ST_EMPTY, '0, 1'b1, 5'd0}},
    '{OP_DUMP,       '0,            1,  1'b1, '{ST_EMPTY, '0, 1'b1, 5'd0}}
  };

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_word_t  in_data_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_word_t out_data_o;

  // shadow copy of the deque
  logic signed [VALUE_W-1:0] shadow_store [DEPTH];
  int unsigned               shadow_front = 0;
  int unsigned               shadow_count = 0;

  out_word_t result_due_q [$];
  fixed_t    fixed_result_q [$];

  logic        quiet = 1'b0;  // no idling on either side while set
  int unsigned err_count = 0;
  int unsigned words_sent = 0;
  int unsigned words_checked = 0;
  int unsigned dumps_seen = 0;
  int unsigned full_drops = 0;
  int unsigned empty_hits = 0;
  int unsigned peak_occ = 0;

  bounded_deque_top #(
    .DEPTH(DEPTH)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (quiet || roll < 40) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic out_word_t deque_word(status_e st, logic signed [VALUE_W-1:0] elem,
                                           logic is_last);
    out_word_t w;
    w.status    = st;
    w.element   = elem;
    w.last      = is_last;
    w.occupancy = OCC_W'(shadow_count);
    return w;
  endfunction

  // apply one opcode to the shadow deque and queue up the words it owes
  task automatic deque_apply(in_word_t w);
    int unsigned k;
    case (w.opcode)
      OP_PUSH_BACK, OP_PUSH_FRONT: begin
        if (shadow_count >= DEPTH) begin
          full_drops++;
          result_due_q.push_back(deque_word(ST_FULL, '0, 1'b1));
        end else begin
          if (w.opcode == OP_PUSH_BACK) begin
            shadow_store[(shadow_front + shadow_count) % DEPTH] = w.value;
          end else begin
            shadow_front = (shadow_front + DEPTH - 1) % DEPTH;
            shadow_store[shadow_front] = w.value;
          end
          shadow_count++;
          result_due_q.push_back(deque_word(ST_OK, '0, 1'b1));
        end
      end
      OP_POP_BACK, OP_POP_FRONT: begin
        if (shadow_count == 0) begin
          empty_hits++;
          result_due_q.push_back(deque_word(ST_EMPTY, '0, 1'b1));
        end else begin
          if (w.opcode == OP_POP_FRONT) shadow_front = (shadow_front + 1) % DEPTH;
          shadow_count--;
          result_due_q.push_back(deque_word(ST_OK, '0, 1'b1));
        end
      end
      OP_DUMP: begin
        dumps_seen++;
        if (shadow_count == 0) begin
          empty_hits++;
          result_due_q.push_back(deque_word(ST_EMPTY, '0, 1'b1));
        end else begin
          for (k = 0; k < shadow_count; k++) begin
            result_due_q.push_back(deque_word(ST_OK,
                shadow_store[(shadow_front + k) % DEPTH], (k + 1 == shadow_count)));
          end
        end
      end
      default: result_due_q.push_back(deque_word(ST_OK, '0, 1'b1));
    endcase
    if (shadow_count > peak_occ) peak_occ = shadow_count;
  endtask

  task automatic match_field(string tag, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      err_count++;
      $display("[%0t] %s mismatch: expected %0d, got %0d", $time, tag,
               $signed(want), $signed(got));
    end
  endtask

  // monitor: check the result word first, then predict from the accepted input word
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (result_due_q.size() == 0) begin
          err_count++;
          $display("[%0t] unexpected result word: expected none, got status %0d element %0d",
                   $time, out_data_o.status, out_data_o.element);
        end else begin
          match_field("status",    32'(result_due_q[0].status),    32'(out_data_o.status));
          match_field("element",   result_due_q[0].element,         out_data_o.element);
          match_field("last",      32'(result_due_q[0].last),      32'(out_data_o.last));
          match_field("occupancy", 32'(result_due_q[0].occupancy), 32'(out_data_o.occupancy));
          void'(result_due_q.pop_front());
          words_checked++;
        end
      end
      if (in_valid_i && in_ready_o) begin
        deque_apply(in_data_i);
        // hand-typed rows override the shadow's answer
        if (fixed_result_q.size() != 0) begin
          if (fixed_result_q[0].lit_on && result_due_q.size() != 0)
            result_due_q[result_due_q.size() - 1] = fixed_result_q[0].lit;
          void'(fixed_result_q.pop_front());
        end
      end
    end
  end

  // one input word; called and returns at a falling edge
  task automatic send_word(in_word_t w, logic lit_on, out_word_t lit);
    int unsigned gap;
    gap = pick_gap();
    fixed_result_q.push_back('{lit_on, lit});
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    words_sent++;
  endtask

  function automatic logic [2:0] pick_opcode(lean_e lean);
    int unsigned roll;
    int unsigned push_pct;
    roll     = $urandom_range(0, 99);
    push_pct = (lean == LEAN_FILL) ? 75 : (lean == LEAN_DRAIN) ? 25 : 50;
    if (roll < 4) return 3'($urandom_range(OP_RSVD_HI, OP_RSVD_LO));
    if (roll < 14) return OP_DUMP;
    if ($urandom_range(0, 99) < push_pct)
      return $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
    return $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
  endfunction

  function automatic logic signed [VALUE_W-1:0] pick_value();
    if ($urandom_range(0, 99) >= 20) return $urandom;
    case ($urandom_range(0, 3))
      0:       return VAL_MAX;
      1:       return VAL_MIN;
      2:       return '0;
      default: return -32'sd1;
    endcase
  endfunction

  // output side back-pressure
  initial begin : sink_pacing
    int unsigned stall;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      stall = pick_gap();
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
  end

  // ends the run if no word moves on either side for too long
  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("[%0t] no word moved for %0d cycles, %0d result words still due",
             $time, STALL_LIMIT, result_due_q.size());
    $display("tb_bounded_deque_top failed");
    $finish;
  end

  initial begin : main_seq
    in_word_t    word;
    lean_e       lean;
    int unsigned phase_end;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    rst_ni     = 1'b0;
    lean       = LEAN_EVEN;
    phase_end  = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed table; repeated rows step the value so each entry differs
    foreach (dir_tab[r]) begin
      for (int unsigned i = 0; i < dir_tab[r].reps; i++) begin
        word.opcode = dir_tab[r].opcode;
        word.value  = dir_tab[r].value + i;
        send_word(word, dir_tab[r].lit_on && (dir_tab[r].reps == 1), dir_tab[r].lit);
      end
    end

    // random part: phases leaning to fill, drain or neither, some with no idling
    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == phase_end) begin
        lean      = lean_e'($urandom_range(0, 2));
        quiet     = ($urandom_range(0, 3) == 0);
        phase_end = n + $urandom_range(15, 50);
      end
      word.opcode = pick_opcode(lean);
      word.value  = pick_value();
      send_word(word, 1'b0, '0);
    end
    in_valid_i <= 1'b0;

    while (result_due_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("%0d words in, %0d result words checked; %0d dumps, %0d full drops,",
             words_sent, words_checked, dumps_seen, full_drops);
    $display("%0d empty answers, peak occupancy %0d of %0d", empty_hits, peak_occ, DEPTH);
    if (err_count == 0) begin
      $display("tb_bounded_deque_top passed");
    end else begin
      $display("tb_bounded_deque_top failed");
    end
    $finish;
  end

endmodule

// File: bounded_deque_top.f
+incdir+src
src/bdq_pkg.sv
src/bdq_ram.sv
src/bdq_ctrl.sv
src/bdq_datapath.sv
src/bounded_deque_top.sv
tb/tb_bounded_deque_top.sv
